>>> sv/smoothed_sine_oscillator_with_pan_assert.svh
// Assertion macros shared by the oscillator checker.
`ifndef SMOOTHED_SINE_OSCILLATOR_WITH_PAN_ASSERT_SVH
`define SMOOTHED_SINE_OSCILLATOR_WITH_PAN_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SSOP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("oscillator assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SSOP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("oscillator assertion failed");

`endif

>>> sv/ssop_pkg.sv
// Shared types and constants of the smoothed sine oscillator with pan.
`default_nettype none

package ssop_pkg;

    localparam int TARGET_W = 31;
    localparam int PAN_W    = 17;
    localparam int SAMPLE_W = 16;
    localparam int PHASE_W  = 32;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 1;

    localparam logic [CFG_INDEX_W-1:0] CFG_VOLUME     = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_NOISE_MODE = 1'b1;

    localparam logic [CFG_DATA_W-1:0] VOLUME_RESET = 16'd6554;
    localparam logic [PAN_W-1:0]      PAN_FULL     = 17'd65536;

    // Digit-serial multiplier geometry.
    localparam int MUL_A_W   = 33;
    localparam int MUL_B_W   = 32;
    localparam int MUL_DIG   = 4;
    localparam int MUL_STEPS = MUL_B_W / MUL_DIG;
    localparam int MUL_CNT_W = $clog2(MUL_STEPS);
    localparam int MUL_SUM_W = MUL_A_W + MUL_DIG + 2;
    localparam int MUL_HI_W  = MUL_SUM_W - MUL_DIG;
    localparam int MUL_P_W   = MUL_HI_W + MUL_B_W;

    // Step smoothing: 0.6 old plus 0.4 target in Q0.16, rounded half up.
    localparam logic signed [MUL_A_W-1:0] COEF_OLD = 33'sd39322;
    localparam logic signed [MUL_A_W-1:0] COEF_TGT = 33'sd26214;
    localparam int STEP_SUM_W = 48;
    localparam int STEP_SHIFT = 16;
    localparam logic [STEP_SUM_W-1:0] STEP_ROUND = 48'h8000;

    // Output scaling: round by 2^31, keep bits from 32 up.
    localparam int OUT_SHIFT = 32;
    localparam logic signed [MUL_P_W-1:0] OUT_ROUND = 67'sh8000_0000;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

    // Noise generator.
    localparam int LFSR_W = 32;
    localparam logic [LFSR_W-1:0] LFSR_SEED = 32'h2545_F491;
    localparam logic [LFSR_W-1:0] LFSR_TAPS = 32'hA300_0000;
    localparam int LFSR_DIG   = 4;
    localparam int NOISE_DIGS = SAMPLE_W / LFSR_DIG;
    localparam int NOISE_CNT_W = $clog2(NOISE_DIGS);

    // Sine table arithmetic, Q30.
    localparam logic [63:0] Q30_ONE     = 64'd1073741824;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam int ENTRY_W = 15;

    typedef enum logic [4:0] {
        S_IDLE,
        S_SM_GO,
        S_SM_WAIT,
        S_STEP,
        S_PHASE,
        S_LOOK_IDX,
        S_LOOK_ROM,
        S_LOOK_CAP,
        S_NS_L,
        S_NS_R,
        S_NS_CAP,
        S_LV_GO,
        S_LV_WAIT,
        S_LG_GO,
        S_LG_WAIT,
        S_RV_GO,
        S_RV_WAIT,
        S_RG_GO,
        S_RG_WAIT,
        S_OUT
    } state_t;

    typedef struct packed {
        logic                        start;
        logic signed [MUL_A_W-1:0]   a1;
        logic signed [MUL_A_W-1:0]   a2;
        logic        [MUL_B_W-1:0]   b1;
        logic        [MUL_B_W-1:0]   b2;
    } mul_cmd_t;

    typedef struct packed {
        logic                        done;
        logic signed [MUL_P_W-1:0]   product;
    } mul_rsp_t;

    function automatic logic signed [SAMPLE_W-1:0] round_sat(
        input logic signed [MUL_P_W-1:0] p
    );
        logic signed [MUL_P_W-1:0]           biased;
        logic signed [MUL_P_W-OUT_SHIFT-1:0] q;
        logic signed [SAMPLE_W-1:0]          r;
        biased = p + OUT_ROUND;
        q = biased[MUL_P_W-1:OUT_SHIFT];
        if (q > SAMPLE_MAX)
        begin
            r = SAMPLE_MAX;
        end
        else if (q < SAMPLE_MIN)
        begin
            r = SAMPLE_MIN;
        end
        else
        begin
            r = q[SAMPLE_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> sv/ssop_mul.sv
// Digit-serial sum of two products, four multiplier bits per cycle.
`default_nettype none

module ssop_mul
    import ssop_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire mul_cmd_t cmd,
    output mul_rsp_t      rsp
);

    logic signed [MUL_A_W-1:0]   a1_reg;
    logic signed [MUL_A_W-1:0]   a2_reg;
    logic        [MUL_B_W-1:0]   b1_reg;
    logic        [MUL_B_W-1:0]   b2_reg;
    logic signed [MUL_HI_W-1:0]  hi_reg;
    logic        [MUL_B_W-1:0]   lo_reg;
    logic        [MUL_CNT_W-1:0] cnt_reg;
    logic                        busy_reg;
    logic                        done_reg;

    logic signed [MUL_A_W+MUL_DIG:0] pp1;
    logic signed [MUL_A_W+MUL_DIG:0] pp2;
    logic signed [MUL_SUM_W-1:0]     sum;

    always_comb
    begin
        pp1 = a1_reg * $signed({1'b0, b1_reg[MUL_DIG-1:0]});
        pp2 = a2_reg * $signed({1'b0, b2_reg[MUL_DIG-1:0]});
        sum = $signed({{(MUL_SUM_W-MUL_HI_W){hi_reg[MUL_HI_W-1]}}, hi_reg})
            + $signed({pp1[MUL_A_W+MUL_DIG], pp1})
            + $signed({pp2[MUL_A_W+MUL_DIG], pp2});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == MUL_CNT_W'(MUL_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            a1_reg <= cmd.a1;
            a2_reg <= cmd.a2;
            b1_reg <= cmd.b1;
            b2_reg <= cmd.b2;
            hi_reg <= '0;
            lo_reg <= '0;
        end
        else if (busy_reg)
        begin
            b1_reg <= b1_reg >> MUL_DIG;
            b2_reg <= b2_reg >> MUL_DIG;
            hi_reg <= sum[MUL_SUM_W-1:MUL_DIG];
            lo_reg <= {sum[MUL_DIG-1:0], lo_reg[MUL_B_W-1:MUL_DIG]};
        end
    end

    assign rsp.done    = done_reg;
    assign rsp.product = $signed({hi_reg, lo_reg});

endmodule

`default_nettype wire

>>> sv/ssop_sine.sv
// Quarter-wave sine lookup with a registered index and a registered table read.
`default_nettype none

module ssop_sine
    import ssop_pkg::*;
#(
    parameter int DEPTH = 1024
)
(
    input  wire logic                       clk,
    input  wire logic        [PHASE_W-1:0]  phase,
    output logic signed      [SAMPLE_W-1:0] sample
);

    localparam int IDX_W  = $clog2(DEPTH + 1);
    localparam int FRAC_W = PHASE_W - 2;
    localparam int PROD_W = FRAC_W + IDX_W;

    typedef logic [ENTRY_W-1:0] rom_t [0:DEPTH];

    function automatic logic [ENTRY_W-1:0] sine_entry(input logic [63:0] idx);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] r;
        x  = (idx * HALF_PI_Q30) / 64'(DEPTH);
        x2 = (x * x) >> 30;
        t  = Q30_ONE;
        t  = Q30_ONE - (((x2 * t) >> 30) / 64'd156);
        t  = Q30_ONE - (((x2 * t) >> 30) / 64'd110);
        t  = Q30_ONE - (((x2 * t) >> 30) / 64'd72);
        t  = Q30_ONE - (((x2 * t) >> 30) / 64'd42);
        t  = Q30_ONE - (((x2 * t) >> 30) / 64'd20);
        t  = Q30_ONE - (((x2 * t) >> 30) / 64'd6);
        s  = (x * t) >> 30;
        r  = (s + 64'd16384) >> 15;
        if (r > 64'd32767)
        begin
            r = 64'd32767;
        end
        return r[ENTRY_W-1:0];
    endfunction

    function automatic rom_t build_rom();
        rom_t rom;
        for (int i = 0; i <= DEPTH; i++)
        begin
            rom[i] = sine_entry(64'(i));
        end
        return rom;
    endfunction

    localparam rom_t SINE_ROM = build_rom();

    logic [PROD_W-1:0]  idx_prod;
    logic [IDX_W-1:0]   idx_raw;
    logic [IDX_W-1:0]   idx_next;
    logic [IDX_W-1:0]   idx_reg;
    logic               neg_reg;
    logic [ENTRY_W-1:0] entry_reg;
    logic               neg_d_reg;

    always_comb
    begin
        idx_prod = PROD_W'(phase[FRAC_W-1:0]) * PROD_W'(DEPTH);
        idx_raw  = idx_prod[PROD_W-1:FRAC_W];
        idx_next = phase[PHASE_W-2] ? (IDX_W'(DEPTH) - idx_raw) : idx_raw;
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        neg_reg   <= phase[PHASE_W-1];
        entry_reg <= SINE_ROM[idx_reg];
        neg_d_reg <= neg_reg;
    end

    assign sample = neg_d_reg ? -$signed({1'b0, entry_reg}) : $signed({1'b0, entry_reg});

endmodule

`default_nettype wire

>>> sv/ssop_lfsr.sv
// Galois noise register that advances four steps per enabled cycle.
`default_nettype none

module ssop_lfsr
    import ssop_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                adv,
    output logic      [SAMPLE_W-1:0] low
);

    logic [LFSR_W-1:0] lfsr_reg;
    logic [LFSR_W-1:0] lfsr_next;
    logic [LFSR_W-1:0] v;

    always_comb
    begin
        v = lfsr_reg;
        for (int k = 0; k < LFSR_DIG; k++)
        begin
            if (v[0])
            begin
                v = (v >> 1) ^ LFSR_TAPS;
            end
            else
            begin
                v = v >> 1;
            end
        end
        lfsr_next = adv ? v : lfsr_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lfsr_reg <= LFSR_SEED;
        end
        else
        begin
            lfsr_reg <= lfsr_next;
        end
    end

    assign low = lfsr_reg[SAMPLE_W-1:0];

endmodule

`default_nettype wire

>>> sv/smoothed_sine_oscillator_with_pan.sv
// Top level of the smoothed sine oscillator with stereo pan.
// A new frame is taken only in the idle state, after the previous result has gone to the output
// register. A noise frame makes four eight-digit passes of the shared digit-serial multiplier;
// a tone frame makes a fifth, for step smoothing, where a noise frame draws noise digits instead.
// The final output load waits while an earlier result still sits in the output register.
// Reset clears phase, step and latched pan, sets volume to 6554, tone mode and the noise seed.
`default_nettype none

module smoothed_sine_oscillator_with_pan
    import ssop_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = 1024
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic        [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic        [CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                          req_valid,
    output logic                               req_ready,
    input  wire logic        [TARGET_W-1:0]    target_step,
    input  wire logic        [PAN_W-1:0]       pan,
    input  wire logic                          first_in_block,
    output logic                               res_valid,
    input  wire logic                          res_ready,
    output logic signed      [SAMPLE_W-1:0]    left_sample,
    output logic signed      [SAMPLE_W-1:0]    right_sample
);

    state_t state_reg;
    state_t state_next;

    logic [CFG_DATA_W-1:0]  volume_reg;
    logic                   noise_mode_reg;
    logic [PHASE_W-1:0]     phase_acc_reg;
    logic [PHASE_W-1:0]     phase_step_reg;
    logic [PAN_W-1:0]       latched_pan_reg;
    logic [TARGET_W-1:0]    target_reg;
    logic [NOISE_CNT_W-1:0] dig_cnt_reg;
    logic [NOISE_CNT_W-1:0] dig_cnt_next;
    logic signed [SAMPLE_W-1:0] samp_l_reg;
    logic signed [SAMPLE_W-1:0] samp_r_reg;
    logic signed [SAMPLE_W-1:0] left_res_reg;
    logic signed [SAMPLE_W-1:0] left_sample_reg;
    logic signed [SAMPLE_W-1:0] right_sample_reg;
    logic                       res_valid_reg;

    mul_cmd_t mul_cmd;
    mul_rsp_t mul_rsp;

    logic signed [SAMPLE_W-1:0] sine_sample;
    logic        [SAMPLE_W-1:0] noise_low;
    logic        [PAN_W-1:0]    pan_clamp;
    logic        [PAN_W-1:0]    lgain;
    logic        [PAN_W-1:0]    rgain;
    logic        [STEP_SUM_W-1:0] step_rnd;
    logic signed [SAMPLE_W-1:0] scaled;

    logic req_xfer;
    logic lfsr_adv;
    logic step_load;
    logic phase_load;
    logic tone_cap;
    logic noise_l_cap;
    logic noise_r_cap;
    logic left_load;
    logic out_load;
    logic cnt_inc;
    logic cnt_clr;

    ssop_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (mul_cmd),
        .rsp   (mul_rsp)
    );

    ssop_sine #(
        .DEPTH (SINE_TABLE_DEPTH)
    ) u_sine (
        .clk    (clk),
        .phase  (phase_acc_reg),
        .sample (sine_sample)
    );

    ssop_lfsr u_lfsr (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (lfsr_adv),
        .low   (noise_low)
    );

    always_comb
    begin
        pan_clamp = (latched_pan_reg > PAN_FULL) ? PAN_FULL : latched_pan_reg;
        lgain     = PAN_FULL - pan_clamp;
        rgain     = pan_clamp;
        step_rnd  = mul_rsp.product[STEP_SUM_W-1:0] + STEP_ROUND;
        scaled    = round_sat(mul_rsp.product);
        req_xfer  = req_valid && req_ready;
    end

    always_comb
    begin
        state_next  = state_reg;
        req_ready   = 1'b0;
        mul_cmd     = '0;
        lfsr_adv    = 1'b0;
        step_load   = 1'b0;
        phase_load  = 1'b0;
        tone_cap    = 1'b0;
        noise_l_cap = 1'b0;
        noise_r_cap = 1'b0;
        left_load   = 1'b0;
        out_load    = 1'b0;
        cnt_inc     = 1'b0;
        cnt_clr     = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                cnt_clr   = 1'b1;
                if (req_valid)
                begin
                    state_next = noise_mode_reg ? S_NS_L : S_SM_GO;
                end
            end
            S_SM_GO:
            begin
                mul_cmd.start = 1'b1;
                mul_cmd.a1    = COEF_OLD;
                mul_cmd.b1    = phase_step_reg;
                mul_cmd.a2    = COEF_TGT;
                mul_cmd.b2    = MUL_B_W'(target_reg);
                state_next    = S_SM_WAIT;
            end
            S_SM_WAIT:
            begin
                if (mul_rsp.done)
                begin
                    state_next = S_STEP;
                end
            end
            S_STEP:
            begin
                step_load  = 1'b1;
                state_next = S_PHASE;
            end
            S_PHASE:
            begin
                phase_load = 1'b1;
                state_next = S_LOOK_IDX;
            end
            S_LOOK_IDX:
            begin
                state_next = S_LOOK_ROM;
            end
            S_LOOK_ROM:
            begin
                state_next = S_LOOK_CAP;
            end
            S_LOOK_CAP:
            begin
                tone_cap   = 1'b1;
                state_next = S_LV_GO;
            end
            S_NS_L:
            begin
                lfsr_adv = 1'b1;
                cnt_inc  = 1'b1;
                if (dig_cnt_reg == NOISE_CNT_W'(NOISE_DIGS - 1))
                begin
                    cnt_clr    = 1'b1;
                    state_next = S_NS_R;
                end
            end
            S_NS_R:
            begin
                lfsr_adv = 1'b1;
                cnt_inc  = 1'b1;
                if (dig_cnt_reg == '0)
                begin
                    noise_l_cap = 1'b1;
                end
                if (dig_cnt_reg == NOISE_CNT_W'(NOISE_DIGS - 1))
                begin
                    cnt_clr    = 1'b1;
                    state_next = S_NS_CAP;
                end
            end
            S_NS_CAP:
            begin
                noise_r_cap = 1'b1;
                state_next  = S_LV_GO;
            end
            S_LV_GO:
            begin
                mul_cmd.start = 1'b1;
                mul_cmd.a1    = $signed({{(MUL_A_W-SAMPLE_W){samp_l_reg[SAMPLE_W-1]}},
                                         samp_l_reg});
                mul_cmd.b1    = MUL_B_W'(volume_reg);
                state_next    = S_LV_WAIT;
            end
            S_LV_WAIT:
            begin
                if (mul_rsp.done)
                begin
                    state_next = S_LG_GO;
                end
            end
            S_LG_GO:
            begin
                mul_cmd.start = 1'b1;
                mul_cmd.a1    = $signed(mul_rsp.product[MUL_A_W-1:0]);
                mul_cmd.b1    = MUL_B_W'(lgain);
                state_next    = S_LG_WAIT;
            end
            S_LG_WAIT:
            begin
                if (mul_rsp.done)
                begin
                    left_load  = 1'b1;
                    state_next = S_RV_GO;
                end
            end
            S_RV_GO:
            begin
                mul_cmd.start = 1'b1;
                mul_cmd.a1    = $signed({{(MUL_A_W-SAMPLE_W){samp_r_reg[SAMPLE_W-1]}},
                                         samp_r_reg});
                mul_cmd.b1    = MUL_B_W'(volume_reg);
                state_next    = S_RV_WAIT;
            end
            S_RV_WAIT:
            begin
                if (mul_rsp.done)
                begin
                    state_next = S_RG_GO;
                end
            end
            S_RG_GO:
            begin
                mul_cmd.start = 1'b1;
                mul_cmd.a1    = $signed(mul_rsp.product[MUL_A_W-1:0]);
                mul_cmd.b1    = MUL_B_W'(rgain);
                state_next    = S_RG_WAIT;
            end
            S_RG_WAIT:
            begin
                if (mul_rsp.done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!res_valid_reg || res_ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cnt_clr)
        begin
            dig_cnt_next = '0;
        end
        else if (cnt_inc)
        begin
            dig_cnt_next = dig_cnt_reg + 1'b1;
        end
        else
        begin
            dig_cnt_next = dig_cnt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            dig_cnt_reg     <= '0;
            volume_reg      <= VOLUME_RESET;
            noise_mode_reg  <= 1'b0;
            phase_acc_reg   <= '0;
            phase_step_reg  <= '0;
            latched_pan_reg <= '0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            dig_cnt_reg <= dig_cnt_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_VOLUME:     volume_reg     <= cfg_data;
                    CFG_NOISE_MODE: noise_mode_reg <= cfg_data[0];
                    default:        ;
                endcase
            end
            if (req_xfer && first_in_block)
            begin
                latched_pan_reg <= pan;
            end
            if (step_load)
            begin
                phase_step_reg <= step_rnd[STEP_SUM_W-1:STEP_SHIFT];
            end
            if (phase_load)
            begin
                phase_acc_reg <= phase_acc_reg + phase_step_reg;
            end
            res_valid_reg <= out_load || (res_valid_reg && !res_ready);
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_xfer)
        begin
            target_reg <= target_step;
        end
        if (tone_cap)
        begin
            samp_l_reg <= sine_sample;
            samp_r_reg <= sine_sample;
        end
        if (noise_l_cap)
        begin
            samp_l_reg <= $signed(noise_low);
        end
        if (noise_r_cap)
        begin
            samp_r_reg <= $signed(noise_low);
        end
        if (left_load)
        begin
            left_res_reg <= scaled;
        end
        if (out_load)
        begin
            left_sample_reg  <= left_res_reg;
            right_sample_reg <= scaled;
        end
    end

    assign res_valid    = res_valid_reg;
    assign left_sample  = left_sample_reg;
    assign right_sample = right_sample_reg;

endmodule

`default_nettype wire

>>> sv/ssop_checker.sv
// Port-level checker of the oscillator and its bind to the top level.
`default_nettype none

`include "smoothed_sine_oscillator_with_pan_assert.svh"

module ssop_checker
    import ssop_pkg::*;
(
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          req_valid,
    input wire logic                          req_ready,
    input wire logic                          res_valid,
    input wire logic                          res_ready,
    input wire logic signed [SAMPLE_W-1:0]    left_sample,
    input wire logic signed [SAMPLE_W-1:0]    right_sample
);

    // Frames taken in whose results have not yet been transferred out.
    logic [1:0] pending_reg;
    logic [1:0] pending_next;

    always_comb
    begin
        pending_next = pending_reg + 2'(req_valid && req_ready) - 2'(res_valid && res_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    `SSOP_ASSERT_NXT(a_busy_after_transfer, clk, rst_n, req_valid && req_ready, !req_ready)
    `SSOP_ASSERT_IMP(a_result_has_source, clk, rst_n, res_valid, pending_reg != 2'd0)
    `SSOP_ASSERT_IMP(a_pending_bound, clk, rst_n, 1'b1, pending_reg != 2'd3)
    `SSOP_ASSERT_NXT(a_result_holds, clk, rst_n, res_valid && !res_ready,
        res_valid && $stable(left_sample) && $stable(right_sample))

endmodule

bind smoothed_sine_oscillator_with_pan ssop_checker u_ssop_checker (.*);

`default_nettype wire

>>> test/smoothed_sine_oscillator_with_pan_test.sv
// Self-checking testbench for the smoothed sine oscillator with stereo pan.
`timescale 1ns / 100ps

module smoothed_sine_oscillator_with_pan_test
    import ssop_pkg::*;
();

    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 7;
    localparam int TABLE_DEPTH   = 1024;
    localparam int RANDOM_FRAMES = 630;
    localparam int SETTLE_CYCLES = 80;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int IDLE_PERCENT  = 35;
    localparam int MAX_GAP       = 70;

    localparam logic [63:0] STEP_OLD_WEIGHT = 64'd39322;
    localparam logic [63:0] STEP_NEW_WEIGHT = 64'd26214;
    localparam logic [63:0] STEP_ROUNDING   = 64'd32768;
    localparam longint unsigned UNIT_Q30      = 64'd1073741824;
    localparam longint unsigned HALF_PI_FIXED = 64'd1686629713;
    localparam longint unsigned SERIES_DIV [6] = '{156, 110, 72, 42, 20, 6};
    localparam logic [31:0] NOISE_SEED = 32'h2545_F491;
    localparam logic [31:0] NOISE_TAPS = 32'hA300_0000;
    localparam logic [PAN_W-1:0] FULL_PAN = 17'd65536;
    localparam logic signed [63:0] PRODUCT_ROUNDING = 64'sd2147483648;

    typedef enum logic {
        ROW_FRAME,
        ROW_CONFIG
    } row_kind_t;

    typedef struct packed {
        row_kind_t                    kind;
        logic        [TARGET_W-1:0]   target;
        logic        [PAN_W-1:0]      pan_value;
        logic                         first;
        logic        [CFG_DATA_W-1:0] volume;
        logic                         noise;
        logic                         typed;
        logic signed [SAMPLE_W-1:0]   left;
        logic signed [SAMPLE_W-1:0]   right;
    } directed_row_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
    } stereo_frame_t;

    localparam int SCRIPT_ROWS = 26;
    localparam directed_row_t SCRIPT [SCRIPT_ROWS] = '{
        '{ROW_FRAME,  31'h0000_0000, 17'd0,      1'b1, 16'd0,     1'b0, 1'b1, 16'sd0, 16'sd0},
        '{ROW_FRAME,  31'h7FFF_FFFF, 17'd65536,  1'b0, 16'd0,     1'b0, 1'b0, 16'sd0, 16'sd0},
        '{ROW_FRAME,  31'h7FFF_FFFF, 17'd65536,  1'b1, 16'd0,     1'b0, 1'b0, 16'sd0, 16'sd0},
        '{ROW_FRAME,  31'h7FFF_FFFF, 17'h1FFFF,  1'b1, 16'd0,     1'b0, 1'b0, 16'sd0, 16'sd0},
        '{ROW_FRAME,  31'h00BC_614E, 17'd32768,  1'b1, 16'd0,     1'b0, 1'b0, 16'sd0, 16'sd0},
        '{ROW_CONFIG, 31'h0000_0000, 17'd0,      1'b0, 16'd0,     1'b0, 1'b0, 16'sd0, 16'sd0},
        '{ROW_FRAME,  31'h7FFF_FFFF, 17'd32768,  1'b1, 16'd0,     1'b0, 1'b1, 16'sd0, 16'sd0},
        '{ROW_FRAME,  31'h1555_5555, 17'h1FFFF,  1'b0, 16'd0,     1'b0, 1'b1, 16'sd0, 16'sd0},
        '{ROW_CONFIG, 31'h0000_0000, 17'd0,      1'b0, 16'hFFFF,  1'b0, 1'b0, 16'sd0, 16'sd0},
        '{ROW_FRAME,  31'h0000_0000, 17'd0,      1'b1, 16'd0,     1'b0, 1'b0, 16'sd0, 16'sd0},
        '{ROW_FRAME,  31'h4000_0000, 17'd65536,  1'b0, 16'd0,     1'b0, 1'b0, 16'sd0, 16'sd0},
        '{ROW_FRAME,  31'h4000_0000, 17'd65536,  1'b1, 16'd0,     1'b0, 1'b0, 16'sd0, 16'sd0},
        '{ROW_FRAME,  31'h2AAA_AAAA, 17'd32768,  1'b1, 16'd0,     1'b0, 1'b0, 16'sd0, 16'sd0},
        '{ROW_FRAME,  31'h0000_0001, 17'd1,      1'b1, 16'd0,     1'b0, 1'b0, 16'sd0, 16'sd0},
        '{ROW_CONFIG, 31'h0000_0000, 17'd0,      1'b0, 16'hFFFF,  1'b1, 1'b0, 16'sd0, 16'sd0},
        '{ROW_FRAME,  31'h0000_0000, 17'd0,      1'b1, 16'd0,     1'b0, 1'b0, 16'sd0, 16'sd0},
        '{ROW_FRAME,  31'h7FFF_FFFF, 17'd65536,  1'b1, 16'd0,     1'b0, 1'b0, 16'sd0, 16'sd0},
        '{ROW_FRAME,  31'h0000_0000, 17'h1FFFF,  1'b1, 16'd0,     1'b0, 1'b0, 16'sd0, 16'sd0},
        '{ROW_FRAME,  31'h0000_0000, 17'd12345,  1'b1, 16'd0,     1'b0, 1'b0, 16'sd0, 16'sd0},
        '{ROW_FRAME,  31'h0000_0000, 17'd54321,  1'b0, 16'd0,     1'b0, 1'b0, 16'sd0, 16'sd0},
        '{ROW_CONFIG, 31'h0000_0000, 17'd0,      1'b0, 16'd0,     1'b1, 1'b0, 16'sd0, 16'sd0},
        '{ROW_FRAME,  31'h7FFF_FFFF, 17'd40000,  1'b1, 16'd0,     1'b0, 1'b1, 16'sd0, 16'sd0},
        '{ROW_CONFIG, 31'h0000_0000, 17'd0,      1'b0, 16'd6554,  1'b0, 1'b0, 16'sd0, 16'sd0},
        '{ROW_FRAME,  31'h7FFF_FFFF, 17'd65535,  1'b1, 16'd0,     1'b0, 1'b0, 16'sd0, 16'sd0},
        '{ROW_FRAME,  31'h1234_5678, 17'd0,      1'b0, 16'd0,     1'b0, 1'b0, 16'sd0, 16'sd0},
        '{ROW_FRAME,  31'h0000_0000, 17'd10000,  1'b1, 16'd0,     1'b0, 1'b0, 16'sd0, 16'sd0}
    };

    logic                          clk            = 1'b0;
    logic                          rst_n          = 1'b0;
    logic                          cfg_we         = 1'b0;
    logic        [CFG_INDEX_W-1:0] cfg_index      = '0;
    logic        [CFG_DATA_W-1:0]  cfg_data       = '0;
    logic                          req_valid      = 1'b0;
    logic                          req_ready;
    logic        [TARGET_W-1:0]    target_step    = '0;
    logic        [PAN_W-1:0]       pan            = '0;
    logic                          first_in_block = 1'b0;
    logic                          res_valid;
    logic                          res_ready      = 1'b0;
    logic signed [SAMPLE_W-1:0]    left_sample;
    logic signed [SAMPLE_W-1:0]    right_sample;

    logic        [CFG_DATA_W-1:0]  gain_volume = VOLUME_RESET;
    logic                          noise_on    = 1'b0;
    logic        [31:0]            tone_phase  = '0;
    logic        [31:0]            tone_step   = '0;
    logic        [PAN_W-1:0]       held_pan    = '0;
    logic        [31:0]            noise_reg   = NOISE_SEED;
    int                            quarter_wave [TABLE_DEPTH+1];

    stereo_frame_t pending_frames [$];
    stereo_frame_t expected_frame;
    logic          no_idle     = 1'b0;
    int            error_count = 0;
    int unsigned   cycle_count = 0;

    smoothed_sine_oscillator_with_pan #(
        .SINE_TABLE_DEPTH(TABLE_DEPTH)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .req_valid     (req_valid),
        .req_ready     (req_ready),
        .target_step   (target_step),
        .pan           (pan),
        .first_in_block(first_in_block),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .left_sample   (left_sample),
        .right_sample  (right_sample)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic int quarter_sine(input longint unsigned idx);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned s;
        longint unsigned r;
        x = (idx * HALF_PI_FIXED) / 64'(TABLE_DEPTH);
        x2 = (x * x) >> 30;
        t = UNIT_Q30;
        for (int k = 0; k < 6; k++)
        begin
            t = UNIT_Q30 - (((x2 * t) >> 30) / SERIES_DIV[k]);
        end
        s = (x * t) >> 30;
        r = (s + 64'd16384) >> 15;
        if (r > 64'd32767)
        begin
            r = 64'd32767;
        end
        return int'(r);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] sine_sample(input logic [31:0] ph);
        longint unsigned idx;
        logic signed [SAMPLE_W-1:0] mag;
        idx = (64'(ph[29:0]) * 64'(TABLE_DEPTH)) >> 30;
        if (ph[30])
        begin
            idx = 64'(TABLE_DEPTH) - idx;
        end
        mag = SAMPLE_W'(quarter_wave[idx]);
        return ph[31] ? -mag : mag;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] draw_noise();
        for (int k = 0; k < 16; k++)
        begin
            noise_reg = noise_reg[0] ? ((noise_reg >> 1) ^ NOISE_TAPS) : (noise_reg >> 1);
        end
        return noise_reg[SAMPLE_W-1:0];
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] scale_sample(
        input logic signed [SAMPLE_W-1:0] s,
        input logic        [PAN_W-1:0]    g
    );
        longint product;
        longint rounded;
        product = longint'(s) * longint'(gain_volume) * longint'(g);
        rounded = (product + PRODUCT_ROUNDING) >>> 32;
        if (rounded > 64'sd32767)
        begin
            rounded = 64'sd32767;
        end
        else if (rounded < -64'sd32768)
        begin
            rounded = -64'sd32768;
        end
        return rounded[SAMPLE_W-1:0];
    endfunction

    task automatic predict_frame(
        input  logic [TARGET_W-1:0] t,
        input  logic [PAN_W-1:0]    p,
        input  logic                f,
        output stereo_frame_t       fr
    );
        logic        [PAN_W-1:0]    eff_pan;
        logic signed [SAMPLE_W-1:0] ls;
        logic signed [SAMPLE_W-1:0] rs;
        logic        [63:0]         eased;
        if (f)
        begin
            held_pan = p;
        end
        eff_pan = (held_pan > FULL_PAN) ? FULL_PAN : held_pan;
        if (noise_on)
        begin
            ls = draw_noise();
            rs = draw_noise();
        end
        else
        begin
            eased = STEP_OLD_WEIGHT * {32'd0, tone_step} + STEP_NEW_WEIGHT * {33'd0, t}
                    + STEP_ROUNDING;
            tone_step = eased[47:16];
            tone_phase = tone_phase + tone_step;
            ls = sine_sample(tone_phase);
            rs = ls;
        end
        fr.left = scale_sample(ls, FULL_PAN - eff_pan);
        fr.right = scale_sample(rs, eff_pan);
    endtask

    task automatic send_frame(
        input logic [TARGET_W-1:0] t,
        input logic [PAN_W-1:0]    p,
        input logic                f,
        input logic                typed,
        input stereo_frame_t       typed_frame
    );
        stereo_frame_t predicted;
        req_valid <= 1'b1;
        target_step <= t;
        pan <= p;
        first_in_block <= f;
        @(posedge clk);
        while (!req_ready)
        begin
            @(posedge clk);
        end
        predict_frame(t, p, f, predicted);
        pending_frames.push_back(typed ? typed_frame : predicted);
        if (!no_idle && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, MAX_GAP)) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        req_valid <= 1'b0;
        do
        begin
            @(negedge clk);
        end
        while (pending_frames.size() != 0);
        @(posedge clk);
    endtask

    task automatic write_config(input logic [CFG_DATA_W-1:0] vol, input logic mode);
        cfg_we <= 1'b1;
        cfg_index <= CFG_VOLUME;
        cfg_data <= vol;
        @(posedge clk);
        cfg_index <= CFG_NOISE_MODE;
        cfg_data <= {{(CFG_DATA_W-1){1'b0}}, mode};
        @(posedge clk);
        cfg_we <= 1'b0;
        gain_volume = vol;
        noise_on = mode;
    endtask

    always @(posedge clk)
    begin
        res_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    always @(posedge clk)
    begin
        if (rst_n && res_valid && res_ready)
        begin
            if (pending_frames.size() == 0)
            begin
                $error("result transfer with no frame pending: left %0d, right %0d",
                       left_sample, right_sample);
                error_count++;
            end
            else
            begin
                expected_frame = pending_frames.pop_front();
                if (left_sample !== expected_frame.left)
                begin
                    $error("left_sample mismatch: expected %0d, actual %0d",
                           expected_frame.left, left_sample);
                    error_count++;
                end
                if (right_sample !== expected_frame.right)
                begin
                    $error("right_sample mismatch: expected %0d, actual %0d",
                           expected_frame.right, right_sample);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        int                    random_sent;
        int                    phase_index;
        int                    burst;
        logic [CFG_DATA_W-1:0] vol_pick;
        logic [TARGET_W-1:0]   hold_target;
        logic [TARGET_W-1:0]   t_pick;
        logic [PAN_W-1:0]      p_pick;
        random_sent = 0;
        phase_index = 0;
        for (int i = 0; i <= TABLE_DEPTH; i++)
        begin
            quarter_wave[i] = quarter_sine(64'(i));
        end
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < SCRIPT_ROWS; i++)
        begin
            if (SCRIPT[i].kind == ROW_CONFIG)
            begin
                drain_results();
                write_config(SCRIPT[i].volume, SCRIPT[i].noise);
            end
            else
            begin
                send_frame(SCRIPT[i].target, SCRIPT[i].pan_value, SCRIPT[i].first,
                           SCRIPT[i].typed, '{SCRIPT[i].left, SCRIPT[i].right});
            end
        end

        while (random_sent < RANDOM_FRAMES)
        begin
            drain_results();
            case ($urandom_range(0, 4))
                0: vol_pick = '0;
                1: vol_pick = '1;
                2: vol_pick = VOLUME_RESET;
                default: vol_pick = CFG_DATA_W'($urandom_range(0, 65535));
            endcase
            no_idle <= (phase_index == 2);
            write_config(vol_pick, $urandom_range(0, 99) < 30);
            hold_target = TARGET_W'($urandom);
            burst = (phase_index == 2) ? 60 : $urandom_range(10, 50);
            repeat (burst)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: t_pick = hold_target;
                    6: t_pick = '1;
                    7: t_pick = TARGET_W'($urandom_range(0, 4095));
                    default: t_pick = TARGET_W'($urandom);
                endcase
                case ($urandom_range(0, 9))
                    0: p_pick = '0;
                    1: p_pick = FULL_PAN;
                    2: p_pick = PAN_W'($urandom_range(65537, 131071));
                    default: p_pick = PAN_W'($urandom_range(0, 65536));
                endcase
                send_frame(t_pick, p_pick, $urandom_range(0, 3) == 0, 1'b0, '0);
                random_sent++;
            end
            phase_index++;
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+sv
sv/ssop_pkg.sv
sv/ssop_mul.sv
sv/ssop_sine.sv
sv/ssop_lfsr.sv
sv/smoothed_sine_oscillator_with_pan.sv
sv/ssop_checker.sv
test/smoothed_sine_oscillator_with_pan_test.sv
